### rtl/mmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmf_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 16;

   // Fixed widths of the configuration and result fields.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CFG_WIDTH_BITS = 11;
   localparam int ROW_BITS       = 16;
   localparam int COL_OUT_BITS   = 10;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPERATION     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBOURHOOD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 2'd3;

   // Field codes.
   localparam logic OP_DILATE    = 1'b0;
   localparam logic OP_ERODE     = 1'b1;
   localparam logic SHAPE_SQUARE = 1'b0;
   localparam logic SHAPE_CROSS  = 1'b1;

   // Reset values of the geometry registers.
   localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [ROW_BITS-1:0]       HEIGHT_RESET = 16'd1024;

   // Which results one item produces, in emission order.
   typedef struct packed {
      logic interior_px;   // window pixel at (r-1, c-1)
      logic right_border;  // right border pixel at (r-1, W-1)
      logic bottom_border; // bottom border pixel at (H-1, c)
      logic frame_done;    // bottom border pixel is the last of the frame
   } mmf_emit_type;

endpackage

`default_nettype wire

### rtl/morph_3x3_min_max_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// 3x3 grayscale dilation (window maximum) or erosion (window minimum) over a
// raster-order frame of signed pixels, on the full square or the five-point cross.
// req_* carries one pixel per item; an item is taken when req_valid is high and
// req_stall is low. rsp_* carries result items with their row and column; each
// pixel yields zero to three results (the bottom border row leaves alongside the
// last input row), and rsp_last_in_run marks the final result of one input item.
// csr_* writes operation, neighbourhood, image_width and image_height; csr_ready
// is always high, and writes belong between frames while the block is empty.
// An accepted pixel passes the memory read stage and then the output register.
// Throughput: one pixel per cycle unless the output holds, limited by the line
// memory, which takes one read and one write per pixel; an item with several
// results holds the output until its last is taken. A pixel waits in the memory
// read stage while results are held; rsp_stall reaches req_stall in the same cycle.
// Reset clears the counters, the window and the pipeline and restores the
// register defaults; the line memory is not cleared, since every entry is
// written in the first two rows before any filtered result depends on it.

module morph_3x3_min_max_filter import mmf_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [PIXEL_BITS-1:0]   req_pixel,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed      [PIXEL_BITS-1:0]   rsp_value,
   output logic             [ROW_BITS-1:0]     rsp_out_row,
   output logic             [COL_OUT_BITS-1:0] rsp_out_column,
   output logic                                rsp_last_in_run,
   output logic                                rsp_frame_done,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic        [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic        [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);

   // Configuration.
   logic                      cfg_op_ff;
   logic                      cfg_shape_ff;
   logic [CFG_WIDTH_BITS-1:0] cfg_width_ff;
   logic [ROW_BITS-1:0]       cfg_height_ff;

   // Geometry after clamping.
   logic [31:0]         w_eff;
   logic [AW-1:0]       w_last;
   logic [ROW_BITS-1:0] h_last;

   // Raster counters.
   logic [AW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [AW-1:0]       c_cur;
   logic [ROW_BITS-1:0] r_cur;

   // Memory read stage.
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [PIXEL_BITS-1:0] s1_pix_ff;
   logic [AW-1:0]                s1_col_ff;
   logic [ROW_BITS-1:0]          s1_row_ff;
   logic                         fwd_ff;
   logic [2*PIXEL_BITS-1:0]      fwd_data_ff;

   logic                         accept;
   logic                         s1_fire;
   logic                         out_free;
   logic [2*PIXEL_BITS-1:0]      mem_rd_data;
   logic [2*PIXEL_BITS-1:0]      pair;
   logic signed [PIXEL_BITS-1:0] s1_upper, s1_middle;
   logic signed [PIXEL_BITS-1:0] win_result;
   logic signed [PIXEL_BITS-1:0] load_value;
   mmf_emit_type                 emit;
   logic                         any_emit;
   logic                         interior;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_op_ff     <= OP_DILATE;
         cfg_shape_ff  <= SHAPE_SQUARE;
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OPERATION:     cfg_op_ff     <= csr_data[0];
            CSR_NEIGHBOURHOOD: cfg_shape_ff  <= csr_data[0];
            CSR_IMAGE_WIDTH:   cfg_width_ff  <= csr_data[CFG_WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT:  cfg_height_ff <= csr_data[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // A zero width or height counts as one; a width above the line memory
   // counts as its depth.
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = 32'd1;
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = 32'(MAX_WIDTH);
      end else begin
         w_eff = 32'(cfg_width_ff);
      end
      w_last = AW'(w_eff - 32'd1);
      h_last = (cfg_height_ff == '0) ? '0 : cfg_height_ff - ROW_BITS'(1);
   end

   // Handshake of the input and the read stage.
   assign any_emit  = emit.interior_px || emit.right_border || emit.bottom_border;
   assign s1_fire   = s1_valid_ff && (!any_emit || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;

   // Counters beyond the current geometry saturate before use.
   always_comb begin
      c_cur  = (col_ff > w_last) ? w_last : col_ff;
      r_cur  = (row_ff > h_last) ? h_last : row_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_cur >= w_last) begin
            col_in = '0;
            row_in = (r_cur >= h_last) ? '0 : r_cur + ROW_BITS'(1);
         end else begin
            col_in = c_cur + AW'(1);
            row_in = r_cur;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // The item leaving the read stage writes its column in the same edge at which
   // the next item reads; with a one-pixel row that is the same entry, so the
   // written pair is carried forward instead of the stale read.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_pixel;
         s1_col_ff   <= c_cur;
         s1_row_ff   <= r_cur;
         fwd_ff      <= s1_fire && (s1_col_ff == c_cur);
         fwd_data_ff <= {s1_middle, s1_pix_ff};
      end
   end

   assign pair      = fwd_ff ? fwd_data_ff : mem_rd_data;
   assign s1_upper  = pair[2*PIXEL_BITS-1:PIXEL_BITS];
   assign s1_middle = pair[PIXEL_BITS-1:0];

   // Each entry holds the column's pixels of the two previous rows.
   mmf_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2*PIXEL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (mem_rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_middle, s1_pix_ff})
   );

   mmf_window #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .shift         (s1_fire),
      .operation     (cfg_op_ff),
      .neighbourhood (cfg_shape_ff),
      .upper         (s1_upper),
      .middle        (s1_middle),
      .lower         (s1_pix_ff),
      .result        (win_result)
   );

   always_comb begin
      emit.interior_px   = (s1_row_ff >= ROW_BITS'(1)) && (s1_col_ff >= AW'(1));
      emit.right_border  = (s1_row_ff >= ROW_BITS'(1)) && (s1_col_ff == w_last);
      emit.bottom_border = (s1_row_ff == h_last);
      emit.frame_done    = (s1_row_ff == h_last) && (s1_col_ff == w_last);
      interior           = (s1_row_ff >= ROW_BITS'(2)) && (s1_col_ff >= AW'(2));
      load_value         = interior ? win_result : '0;
   end

   mmf_out_queue #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_out_queue (
      .clock           (clock),
      .reset           (reset),
      .load            (s1_fire && any_emit),
      .emit            (emit),
      .load_value      (load_value),
      .load_row        (s1_row_ff),
      .load_column     (s1_col_ff),
      .h_last          (h_last),
      .w_last          (w_last),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_column  (rsp_out_column),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule

`default_nettype wire

### rtl/mmf_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module mmf_line_mem #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_BITS-1:0]     rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0]     wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/mmf_window.sv
`timescale 1ns / 1ps
`default_nettype none

module mmf_window import mmf_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         shift,
   input  wire logic                         operation,
   input  wire logic                         neighbourhood,
   input  wire logic signed [PIXEL_BITS-1:0] upper,
   input  wire logic signed [PIXEL_BITS-1:0] middle,
   input  wire logic signed [PIXEL_BITS-1:0] lower,
   output logic signed      [PIXEL_BITS-1:0] result
);

   // Entries 0..2 hold column c-2 (upper, middle, lower), entries 3..5 column c-1.
   logic signed [PIXEL_BITS-1:0] win_ff [6];

   logic signed [PIXEL_BITS-1:0] x0, x2, xu, xp;
   logic signed [PIXEL_BITS-1:0] t_a, t_b, t_c, t_d, t_ab, t_cd, t_abcd;

   function automatic logic signed [PIXEL_BITS-1:0] pick(
      input logic                         op,
      input logic signed [PIXEL_BITS-1:0] a,
      input logic signed [PIXEL_BITS-1:0] b
   );
      logic a_less;
      a_less = (a < b);
      if (op == OP_ERODE) begin
         return a_less ? a : b;
      end
      return a_less ? b : a;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= upper;
         win_ff[4] <= middle;
         win_ff[5] <= lower;
      end
   end

   // The cross leaves out the corners; the center stands in for them, which
   // leaves a maximum or minimum unchanged.
   always_comb begin
      if (neighbourhood == SHAPE_CROSS) begin
         x0 = win_ff[4];
         x2 = win_ff[4];
         xu = win_ff[4];
         xp = win_ff[4];
      end else begin
         x0 = win_ff[0];
         x2 = win_ff[2];
         xu = upper;
         xp = lower;
      end
      t_a    = pick(operation, win_ff[4], win_ff[1]);
      t_b    = pick(operation, middle, win_ff[3]);
      t_c    = pick(operation, win_ff[5], x0);
      t_d    = pick(operation, x2, xu);
      t_ab   = pick(operation, t_a, t_b);
      t_cd   = pick(operation, t_c, t_d);
      t_abcd = pick(operation, t_ab, t_cd);
      result = pick(operation, t_abcd, xp);
   end

endmodule

`default_nettype wire

### rtl/mmf_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mmf_out_queue import mmf_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load,
   input  wire mmf_emit_type                     emit,
   input  wire logic signed [PIXEL_BITS-1:0]     load_value,
   input  wire logic        [ROW_BITS-1:0]       load_row,
   input  wire logic        [$clog2(MAX_WIDTH)-1:0] load_column,
   input  wire logic        [ROW_BITS-1:0]       h_last,
   input  wire logic        [$clog2(MAX_WIDTH)-1:0] w_last,
   output logic                                  free,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed      [PIXEL_BITS-1:0]     rsp_value,
   output logic             [ROW_BITS-1:0]       rsp_out_row,
   output logic             [COL_OUT_BITS-1:0]   rsp_out_column,
   output logic                                  rsp_last_in_run,
   output logic                                  rsp_frame_done
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [2:0]                   pend_ff, pend_in;
   logic signed [PIXEL_BITS-1:0] value_ff;
   logic [ROW_BITS-1:0]          row_ff;
   logic [AW-1:0]                col_ff;
   logic                         done_ff;

   logic [2:0]                   pend_rest;
   logic                         take;
   logic [AW-1:0]                col_sel;
   logic [AW+COL_OUT_BITS-1:0]   col_ext;

   // The lowest pending slot goes out first.
   assign pend_rest = pend_ff & (pend_ff - 3'd1);
   assign rsp_valid = |pend_ff;
   assign take      = rsp_valid && !rsp_stall;
   assign rsp_last_in_run = (pend_rest == 3'd0);
   assign free      = !rsp_valid || (take && rsp_last_in_run);

   always_comb begin
      pend_in = pend_ff;
      if (take) begin
         pend_in = pend_rest;
      end
      if (load) begin
         pend_in = {emit.bottom_border, emit.right_border, emit.interior_px};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= load_value;
         row_ff   <= load_row;
         col_ff   <= load_column;
         done_ff  <= emit.frame_done;
      end
   end

   always_comb begin
      if (pend_ff[0]) begin
         rsp_value      = value_ff;
         rsp_out_row    = row_ff - ROW_BITS'(1);
         col_sel        = col_ff - AW'(1);
         rsp_frame_done = 1'b0;
      end else if (pend_ff[1]) begin
         rsp_value      = '0;
         rsp_out_row    = row_ff - ROW_BITS'(1);
         col_sel        = w_last;
         rsp_frame_done = 1'b0;
      end else begin
         rsp_value      = '0;
         rsp_out_row    = h_last;
         col_sel        = col_ff;
         rsp_frame_done = done_ff;
      end
      col_ext        = {{COL_OUT_BITS{1'b0}}, col_sel};
      rsp_out_column = col_ext[COL_OUT_BITS-1:0];
   end

endmodule

`default_nettype wire
